// ----- rtl/bpe_pkg.sv -----
// Shared types, constants and curve tables for the battery percent estimator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package bpe_pkg;

    localparam int ADC_W    = 12;
    localparam int GAIN_W   = 18;
    localparam int OFFS_W   = 11;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 1;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 7;
    localparam int Q8_W     = 22;
    localparam int S_W      = 32;
    localparam int PROD_W   = 37;
    localparam int X_W      = 17;
    localparam int REM_W    = 23;
    localparam int SEG_W    = 3;
    localparam int QUO_W    = 5;
    localparam int K_W      = 3;

    localparam int SEGS      = 7;
    localparam int DIV_STEPS = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;

    // voltage window in mV, Q16
    localparam logic signed [S_W-1:0] LO_Q16   = 32'sd196608000;
    localparam logic signed [S_W-1:0] HI_Q16   = 32'sd281804800;
    localparam logic signed [S_W-1:0] HALF_Q16 = 32'sd32768;

    localparam logic signed [PROD_W-1:0] ALPHA_Q16  = 37'sd7864;
    localparam logic signed [PROD_W-1:0] HALF_STEP  = 37'sd32768;
    localparam logic signed [Q8_W:0]     HYST_Q8    = 23'sd1536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_FILT,
        ST_UPD,
        ST_SEG,
        ST_SCALE,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic check;
        logic filt;
        logic upd;
        logic seg;
        logic scale;
        logic div;
        logic apply;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic seeded;
        logic div_done;
        logic out_free;
    } status_t;

    // curve segment s runs from point s to point s+1
    function automatic logic [Q8_W-1:0] seg_lo_q8(input logic [SEG_W-1:0] s);
        logic [Q8_W-1:0] r;
        begin
            unique case (s)
                3'd0:    r = 22'd819200;
                3'd1:    r = 22'd896000;
                3'd2:    r = 22'd934400;
                3'd3:    r = 22'd960000;
                3'd4:    r = 22'd985600;
                3'd5:    r = 22'd1011200;
                3'd6:    r = 22'd1036800;
                default: r = 22'd1036800;
            endcase
            return r;
        end
    endfunction

    function automatic logic [X_W-1:0] seg_den_q8(input logic [SEG_W-1:0] s);
        logic [X_W-1:0] r;
        begin
            unique case (s)
                3'd0:    r = 17'd76800;
                3'd1:    r = 17'd38400;
                3'd2:    r = 17'd25600;
                3'd3:    r = 17'd25600;
                3'd4:    r = 17'd25600;
                3'd5:    r = 17'd25600;
                3'd6:    r = 17'd28160;
                default: r = 17'd28160;
            endcase
            return r;
        end
    endfunction

    function automatic logic [QUO_W-1:0] seg_dp(input logic [SEG_W-1:0] s);
        logic [QUO_W-1:0] r;
        begin
            unique case (s)
                3'd0:    r = 5'd5;
                3'd1:    r = 5'd10;
                3'd2:    r = 5'd20;
                3'd3:    r = 5'd20;
                3'd4:    r = 5'd20;
                3'd5:    r = 5'd15;
                3'd6:    r = 5'd10;
                default: r = 5'd10;
            endcase
            return r;
        end
    endfunction

    function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] s);
        logic [PCT_W-1:0] r;
        begin
            unique case (s)
                3'd0:    r = 7'd0;
                3'd1:    r = 7'd5;
                3'd2:    r = 7'd15;
                3'd3:    r = 7'd35;
                3'd4:    r = 7'd55;
                3'd5:    r = 7'd75;
                3'd6:    r = 7'd90;
                default: r = 7'd90;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bpe_ctrl.sv -----
// Sequencer for the battery percent estimator: steps one reading through the datapath.
// Depends on bpe_pkg (state_t, cmd_t, status_t).
`default_nettype none

module bpe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bpe_pkg::status_t  status,
    output bpe_pkg::cmd_t          cmd
);

    bpe_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bpe_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bpe_pkg::ST_MUL;
            end
            bpe_pkg::ST_MUL:   state_next = bpe_pkg::ST_CHECK;
            bpe_pkg::ST_CHECK:
            begin
                if (status.reject)
                    state_next = bpe_pkg::ST_DONE;
                else if (status.seeded)
                    state_next = bpe_pkg::ST_FILT;
                else
                    state_next = bpe_pkg::ST_SEG;
            end
            bpe_pkg::ST_FILT:  state_next = bpe_pkg::ST_UPD;
            bpe_pkg::ST_UPD:   state_next = bpe_pkg::ST_SEG;
            bpe_pkg::ST_SEG:   state_next = bpe_pkg::ST_SCALE;
            bpe_pkg::ST_SCALE: state_next = bpe_pkg::ST_DIV;
            bpe_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = bpe_pkg::ST_APPLY;
            end
            bpe_pkg::ST_APPLY: state_next = bpe_pkg::ST_DONE;
            bpe_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = bpe_pkg::ST_IDLE;
            end
            default:           state_next = bpe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            bpe_pkg::ST_MUL:   cmd.mul   = 1'b1;
            bpe_pkg::ST_CHECK: cmd.check = 1'b1;
            bpe_pkg::ST_FILT:  cmd.filt  = 1'b1;
            bpe_pkg::ST_UPD:   cmd.upd   = 1'b1;
            bpe_pkg::ST_SEG:   cmd.seg   = 1'b1;
            bpe_pkg::ST_SCALE: cmd.scale = 1'b1;
            bpe_pkg::ST_DIV:   cmd.div   = 1'b1;
            bpe_pkg::ST_APPLY: cmd.apply = 1'b1;
            bpe_pkg::ST_DONE:  cmd.load_out = status.out_free;
            default:           cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bpe_datapath.sv -----
// Datapath of the battery percent estimator: scaling, window check, filter, curve
// lookup with a restoring divider, hysteresis and the output register. Uses bpe_pkg.
`default_nettype none

module bpe_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bpe_pkg::cmd_t                     cmd,
    output bpe_pkg::status_t                       status,
    input  wire logic [bpe_pkg::ADC_W-1:0]         adc_mv,
    input  wire logic                              cfg_we,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpe_pkg::CFG_W-1:0]         cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bpe_pkg::MV_W-1:0]               battery_mv,
    output logic                                   reading_valid,
    output logic [bpe_pkg::PCT_W-1:0]              percent
);

    // configuration and filter state
    logic [bpe_pkg::GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [bpe_pkg::OFFS_W-1:0] offset_reg, offset_next;
    logic                              seeded_reg, seeded_next;
    logic [bpe_pkg::Q8_W-1:0]          sm_reg, sm_next;
    logic [bpe_pkg::Q8_W-1:0]          ref_reg, ref_next;
    logic [bpe_pkg::PCT_W-1:0]         shown_reg, shown_next;
    logic                              ovalid_reg, ovalid_next;

    // per-transaction working registers
    logic [bpe_pkg::ADC_W-1:0]         adc_reg, adc_next;
    logic signed [bpe_pkg::S_W-1:0]    s_reg, s_next;
    logic [bpe_pkg::MV_W-1:0]          mv_reg, mv_next;
    logic                              valid_reg, valid_next;
    logic [bpe_pkg::Q8_W-1:0]          cv_reg, cv_next;
    logic signed [bpe_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bpe_pkg::SEG_W-1:0]         seg_reg, seg_next;
    logic [bpe_pkg::X_W-1:0]           x_reg, x_next;
    logic [bpe_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [bpe_pkg::QUO_W-1:0]         q_reg, q_next;
    logic [bpe_pkg::K_W-1:0]           k_reg, k_next;
    logic [bpe_pkg::PCT_W-1:0]         pct_reg, pct_next;
    logic [bpe_pkg::MV_W-1:0]          omv_reg, omv_next;
    logic                              oval_reg, oval_next;
    logic [bpe_pkg::PCT_W-1:0]         opct_reg, opct_next;

    // combinational helpers
    logic [bpe_pkg::ADC_W+bpe_pkg::GAIN_W-1:0] scaled;
    logic signed [bpe_pkg::S_W-1:0]    s_round;
    logic [bpe_pkg::MV_W-1:0]          mv_sat;
    logic                              adc_zero;
    logic                              in_window;
    logic signed [bpe_pkg::Q8_W:0]     diff;
    logic signed [bpe_pkg::PROD_W-1:0] step_sh;
    logic signed [bpe_pkg::Q8_W+1:0]   sm_sum;
    logic [bpe_pkg::SEG_W-1:0]         seg_sel;
    logic [bpe_pkg::X_W-1:0]           x_sel;
    logic [bpe_pkg::Q8_W-1:0]          cv_off;
    logic [bpe_pkg::REM_W-1:0]         trial;
    logic [bpe_pkg::PCT_W-1:0]         cand;
    logic signed [bpe_pkg::Q8_W:0]     change;

    assign adc_zero  = (adc_reg == '0);
    assign scaled    = adc_reg * gain_reg;
    assign s_round   = s_reg + bpe_pkg::HALF_Q16;
    assign in_window = (s_reg >= bpe_pkg::LO_Q16) && (s_reg <= bpe_pkg::HI_Q16);

    always_comb
    begin
        if (s_round[bpe_pkg::S_W-1])
            mv_sat = '0;
        else if (s_round[30])
            mv_sat = '1;
        else
            mv_sat = s_round[29:16];
    end

    assign diff    = $signed({1'b0, cv_reg}) - $signed({1'b0, sm_reg});
    assign step_sh = (prod_reg + bpe_pkg::HALF_STEP) >>> 16;
    assign sm_sum  = $signed({2'b00, sm_reg}) + $signed(step_sh[bpe_pkg::Q8_W+1:0]);

    // segment whose upper point is the first at or above the voltage
    always_comb
    begin
        seg_sel = bpe_pkg::SEG_W'(bpe_pkg::SEGS - 1);
        for (int s = bpe_pkg::SEGS - 1; s >= 0; s--)
        begin
            if (cv_reg <= bpe_pkg::seg_lo_q8(bpe_pkg::SEG_W'(s))
                          + bpe_pkg::Q8_W'(bpe_pkg::seg_den_q8(bpe_pkg::SEG_W'(s))))
                seg_sel = bpe_pkg::SEG_W'(s);
        end
        cv_off = cv_reg - bpe_pkg::seg_lo_q8(seg_sel);
        if (cv_reg <= bpe_pkg::seg_lo_q8('0))
            x_sel = '0;
        else if (cv_off > bpe_pkg::Q8_W'(bpe_pkg::seg_den_q8(seg_sel)))
            x_sel = bpe_pkg::seg_den_q8(seg_sel);   // above the last point
        else
            x_sel = cv_off[bpe_pkg::X_W-1:0];
    end

    assign trial  = bpe_pkg::REM_W'({bpe_pkg::seg_den_q8(seg_reg), 1'b0}) << k_reg;
    assign cand   = bpe_pkg::seg_base(seg_reg) + bpe_pkg::PCT_W'(q_reg);
    assign change = $signed({1'b0, sm_reg}) - $signed({1'b0, ref_reg});

    always_comb
    begin
        gain_next   = gain_reg;
        offset_next = offset_reg;
        seeded_next = seeded_reg;
        sm_next     = sm_reg;
        ref_next    = ref_reg;
        shown_next  = shown_reg;
        adc_next    = adc_reg;
        s_next      = s_reg;
        mv_next     = mv_reg;
        valid_next  = valid_reg;
        cv_next     = cv_reg;
        prod_next   = prod_reg;
        seg_next    = seg_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        pct_next    = pct_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                bpe_pkg::REG_GAIN:   gain_next   = cfg_data;
                bpe_pkg::REG_OFFSET: offset_next = $signed(cfg_data[bpe_pkg::OFFS_W-1:0]);
                default:             gain_next   = gain_reg;
            endcase
        end

        if (cmd.load_in)
            adc_next = adc_mv;

        if (cmd.mul)
            s_next = $signed({2'b00, scaled})
                   + $signed({{(bpe_pkg::S_W - bpe_pkg::OFFS_W - 16){offset_reg[bpe_pkg::OFFS_W-1]}},
                              offset_reg, 16'h0000});

        if (cmd.check)
        begin
            mv_next    = adc_zero ? '0 : mv_sat;
            valid_next = in_window && !adc_zero;
            cv_next    = s_reg[29:8];
            pct_next   = '0;
        end

        if (cmd.filt)
            prod_next = bpe_pkg::PROD_W'(diff) * bpe_pkg::ALPHA_Q16;

        if (cmd.upd)
        begin
            sm_next = sm_sum[bpe_pkg::Q8_W-1:0];
            cv_next = sm_sum[bpe_pkg::Q8_W-1:0];
        end

        if (cmd.seg)
        begin
            seg_next = seg_sel;
            x_next   = x_sel;
        end

        // rounded quotient: (x*dp*2 + den) / (2*den)
        if (cmd.scale)
        begin
            rem_next = bpe_pkg::REM_W'(x_reg) * bpe_pkg::REM_W'({bpe_pkg::seg_dp(seg_reg), 1'b0})
                     + bpe_pkg::REM_W'(bpe_pkg::seg_den_q8(seg_reg));
            q_next   = '0;
            k_next   = bpe_pkg::K_W'(bpe_pkg::DIV_STEPS - 1);
        end

        if (cmd.div)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                q_next   = {q_reg[bpe_pkg::QUO_W-2:0], 1'b1};
            end
            else
                q_next   = {q_reg[bpe_pkg::QUO_W-2:0], 1'b0};
            k_next = k_reg - 1'b1;
        end

        if (cmd.apply)
        begin
            if (!seeded_reg)
            begin
                seeded_next = 1'b1;
                sm_next     = cv_reg;
                ref_next    = cv_reg;
                shown_next  = cand;
                pct_next    = cand;
            end
            else if (((cand > shown_reg) && (change >= bpe_pkg::HYST_Q8)) ||
                     ((cand < shown_reg) && (change <= -bpe_pkg::HYST_Q8)))
            begin
                shown_next = cand;
                ref_next   = sm_reg;
                pct_next   = cand;
            end
            else
                pct_next   = shown_reg;
        end
    end

    // output register: holds a result until the consumer takes it
    always_comb
    begin
        ovalid_next = ovalid_reg;
        omv_next    = omv_reg;
        oval_next   = oval_reg;
        opct_next   = opct_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        if (cmd.load_out)
        begin
            ovalid_next = 1'b1;
            omv_next    = mv_reg;
            oval_next   = valid_reg;
            opct_next   = pct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= bpe_pkg::GAIN_RESET;
            offset_reg <= '0;
            seeded_reg <= 1'b0;
            sm_reg     <= '0;
            ref_reg    <= '0;
            shown_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            gain_reg   <= gain_next;
            offset_reg <= offset_next;
            seeded_reg <= seeded_next;
            sm_reg     <= sm_next;
            ref_reg    <= ref_next;
            shown_reg  <= shown_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg   <= adc_next;
        s_reg     <= s_next;
        mv_reg    <= mv_next;
        valid_reg <= valid_next;
        cv_reg    <= cv_next;
        prod_reg  <= prod_next;
        seg_reg   <= seg_next;
        x_reg     <= x_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        pct_reg   <= pct_next;
        omv_reg   <= omv_next;
        oval_reg  <= oval_next;
        opct_reg  <= opct_next;
    end

    assign status.reject   = adc_zero || !in_window;
    assign status.seeded   = seeded_reg;
    assign status.div_done = (k_reg == '0);
    assign status.out_free = !ovalid_reg || !out_stall;

    assign out_valid     = ovalid_reg;
    assign battery_mv    = omv_reg;
    assign reading_valid = oval_reg;
    assign percent       = opct_reg;

endmodule

`default_nettype wire

// ----- rtl/battery_percent_estimator_top.sv -----
// Battery percent estimator top level: controller plus datapath.
// Depends on bpe_pkg, bpe_ctrl and bpe_datapath.
//
// One ADC reading per transaction gives one result. A reading is taken only
// while the sequencer is idle; a rejected reading (zero, or outside
// 3000..4300 mV) ends after the window check. Each other reading runs
// through one shared datapath: scale multiply, window check, filter multiply
// and update (skipped for the first valid reading), curve segment search,
// interpolation multiply and a five-step restoring divider for the rounded
// percent. The finished result sits in an output register, so the next
// reading is accepted while it waits; the sequencer only pauses at its last
// step if that register is still full.
// Configuration writes take effect at once and belong in idle time.
`default_nettype none

module battery_percent_estimator_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bpe_pkg::ADC_W-1:0]         adc_mv,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bpe_pkg::MV_W-1:0]               battery_mv,
    output logic                                   reading_valid,
    output logic [bpe_pkg::PCT_W-1:0]              percent,
    input  wire logic                              cfg_we,
    input  wire logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpe_pkg::CFG_W-1:0]         cfg_data
);

    bpe_pkg::cmd_t    cmd;
    bpe_pkg::status_t status;

    bpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .adc_mv        (adc_mv),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .battery_mv    (battery_mv),
        .reading_valid (reading_valid),
        .percent       (percent)
    );

endmodule

`default_nettype wire
